// ===== rtl/rmis_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmis_pkg
// Shared types, codes and message tables of the radio modem setup sequencer.
// ----------------------------------------------------------------------------
package rmis_pkg;

    localparam int JOBQ_DEPTH = 4;
    localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);
    localparam int MSG_IW     = 5;

    localparam logic [7:0] GUARD_RST   = 8'd110;
    localparam logic [7:0] SETTLE_RST  = 8'd10;
    localparam logic [7:0] TIMEOUT_RST = 8'd255;

    localparam logic [7:0] CHAR_O  = 8'h4F;
    localparam logic [7:0] CHAR_K  = 8'h4B;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    typedef enum logic [1:0] {
        CFG_GUARD   = 2'd0,
        CFG_SETTLE  = 2'd1,
        CFG_TIMEOUT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OKM_IDLE = 2'd0,
        OKM_O    = 2'd1,
        OKM_OK   = 2'd2
    } t_okm;

    typedef enum logic [3:0] {
        PH_GUARD1   = 4'd0,
        PH_ESC1     = 4'd1,
        PH_GUARD2   = 4'd2,
        PH_BAUD     = 4'd3,
        PH_BAUD_WT  = 4'd4,
        PH_GUARD3   = 4'd5,
        PH_ESC2     = 4'd6,
        PH_GUARD4   = 4'd7,
        PH_SETUP    = 4'd8,
        PH_OK_WAIT  = 4'd9,
        PH_EXIT     = 4'd10,
        PH_SETTLE   = 4'd11,
        PH_REPORT   = 4'd12,
        PH_DONE     = 4'd13,
        PH_HALT     = 4'd14
    } t_phase;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_FAST   = 2'd1,
        KIND_REPORT = 2'd2,
        KIND_FAIL   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        JOB_ESCAPE = 3'd0,
        JOB_BAUD   = 3'd1,
        JOB_SETUP  = 3'd2,
        JOB_EXIT   = 3'd3,
        JOB_FAST   = 3'd4,
        JOB_REPORT = 3'd5,
        JOB_FAIL   = 3'd6
    } t_job;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] tx_byte;
        logic       last;
    } t_result;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_req;

    function automatic logic [MSG_IW-1:0] job_len(input t_job job);
        logic [MSG_IW-1:0] len;
        unique case (job)
            JOB_ESCAPE: len = MSG_IW'(3);
            JOB_BAUD:   len = MSG_IW'(6);
            JOB_SETUP:  len = MSG_IW'(19);
            JOB_EXIT:   len = MSG_IW'(5);
            default:    len = MSG_IW'(1);
        endcase
        return len;
    endfunction

    function automatic t_kind job_kind(input t_job job);
        t_kind k;
        unique case (job)
            JOB_FAST:   k = KIND_FAST;
            JOB_REPORT: k = KIND_REPORT;
            JOB_FAIL:   k = KIND_FAIL;
            default:    k = KIND_TX;
        endcase
        return k;
    endfunction

    // "+++", "ATBD7\r", "ATMY20 DL18 ID6219\r", "ATCN\r"
    function automatic logic [7:0] job_char(input t_job job, input logic [MSG_IW-1:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (job)
            JOB_ESCAPE: c = 8'h2B;
            JOB_BAUD: begin
                unique case (idx)
                    5'd0:    c = 8'h41;
                    5'd1:    c = 8'h54;
                    5'd2:    c = 8'h42;
                    5'd3:    c = 8'h44;
                    5'd4:    c = 8'h37;
                    default: c = CHAR_CR;
                endcase
            end
            JOB_SETUP: begin
                unique case (idx)
                    5'd0:    c = 8'h41;
                    5'd1:    c = 8'h54;
                    5'd2:    c = 8'h4D;
                    5'd3:    c = 8'h59;
                    5'd4:    c = 8'h32;
                    5'd5:    c = 8'h30;
                    5'd6:    c = 8'h20;
                    5'd7:    c = 8'h44;
                    5'd8:    c = 8'h4C;
                    5'd9:    c = 8'h31;
                    5'd10:   c = 8'h38;
                    5'd11:   c = 8'h20;
                    5'd12:   c = 8'h49;
                    5'd13:   c = 8'h44;
                    5'd14:   c = 8'h36;
                    5'd15:   c = 8'h32;
                    5'd16:   c = 8'h31;
                    5'd17:   c = 8'h39;
                    default: c = CHAR_CR;
                endcase
            end
            JOB_EXIT: begin
                unique case (idx)
                    5'd0:    c = 8'h41;
                    5'd1:    c = 8'h54;
                    5'd2:    c = 8'h43;
                    5'd3:    c = 8'h4E;
                    default: c = CHAR_CR;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/radio_modem_init_sequencer.sv =====
`default_nettype none
// A tick's job passes the job queue and the job register, and its first result is registered in the output stage.
// Input takes one item per cycle while the four-entry job queue has room.
// A message drains at one item per cycle while results are popped; the next job is read only after the last item.
// Reset (synchronous, active low) restores register defaults, empties queues.
// ----------------------------------------------------------------------------
// radio_modem_init_sequencer
// Walks a serial radio modem through its command-mode setup and reports
// bytes to send, baud switch, start of reporting or timeout failure.
// ----------------------------------------------------------------------------
module radio_modem_init_sequencer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire rmis_pkg::t_item    i_item,
    input  wire logic               pop,
    output logic                    empty,
    output rmis_pkg::t_result       o_result,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [7:0]         i_cfg_data
);

    rmis_pkg::t_job_req job_req;
    rmis_pkg::t_job     job;
    logic               jobq_full, jobq_empty, jobq_rd;

    assign full = jobq_full;

    rmis_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_jobq_full (jobq_full),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_job_req   (job_req)
    );

    rmis_jobq u_jobq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_req (job_req),
        .i_rd      (jobq_rd),
        .o_full    (jobq_full),
        .o_empty   (jobq_empty),
        .o_job     (job)
    );

    rmis_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_jobq_empty (jobq_empty),
        .i_job        (job),
        .o_jobq_rd    (jobq_rd),
        .pop          (pop),
        .empty        (empty),
        .o_result     (o_result)
    );

endmodule
`default_nettype wire

// ===== rtl/rmis_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmis_front
// Takes ticks and received bytes, walks the setup phases and issues one job
// per tick that calls for output. Holds the configuration registers.
// ----------------------------------------------------------------------------
module rmis_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic              i_jobq_full,
    input  wire rmis_pkg::t_item   i_item,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [7:0]        i_cfg_data,
    output rmis_pkg::t_job_req     o_job_req
);

    rmis_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_wait, n_wait;
    rmis_pkg::t_okm   r_ok, n_ok;
    logic [7:0]       r_guard, r_settle, r_timeout;
    logic             accept;
    logic             tick;
    logic [7:0]       wait_inc;

    assign accept   = i_push && !i_jobq_full;
    assign tick     = accept && !i_item.cmd;
    assign wait_inc = r_wait + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guard   <= rmis_pkg::GUARD_RST;
            r_settle  <= rmis_pkg::SETTLE_RST;
            r_timeout <= rmis_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rmis_pkg::CFG_GUARD:   r_guard   <= i_cfg_data;
                rmis_pkg::CFG_SETTLE:  r_settle  <= i_cfg_data;
                rmis_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rmis_pkg::PH_GUARD1;
            r_wait  <= 8'd0;
            r_ok    <= rmis_pkg::OKM_IDLE;
        end else begin
            r_phase <= n_phase;
            r_wait  <= n_wait;
            r_ok    <= n_ok;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_wait  = r_wait;
        n_ok    = r_ok;
        if (accept && i_item.cmd) begin
            if (r_phase == rmis_pkg::PH_OK_WAIT) begin
                n_wait = 8'd0;
                unique case (r_ok)
                    rmis_pkg::OKM_IDLE: begin
                        if (i_item.rx_byte == rmis_pkg::CHAR_O) n_ok = rmis_pkg::OKM_O;
                    end
                    rmis_pkg::OKM_O: begin
                        n_ok = (i_item.rx_byte == rmis_pkg::CHAR_K) ?
                               rmis_pkg::OKM_OK : rmis_pkg::OKM_IDLE;
                    end
                    default: begin
                        if (i_item.rx_byte == rmis_pkg::CHAR_CR) n_phase = rmis_pkg::PH_EXIT;
                    end
                endcase
            end
        end else if (tick) begin
            unique case (r_phase)
                rmis_pkg::PH_GUARD1: begin
                    if (r_wait < r_guard) n_wait = wait_inc;
                    else n_phase = rmis_pkg::PH_ESC1;
                end
                rmis_pkg::PH_GUARD2: begin
                    if (r_wait < r_guard) n_wait = wait_inc;
                    else n_phase = rmis_pkg::PH_BAUD;
                end
                rmis_pkg::PH_GUARD3: begin
                    if (r_wait < r_guard) n_wait = wait_inc;
                    else n_phase = rmis_pkg::PH_ESC2;
                end
                rmis_pkg::PH_GUARD4: begin
                    if (r_wait < r_guard) n_wait = wait_inc;
                    else n_phase = rmis_pkg::PH_SETUP;
                end
                rmis_pkg::PH_ESC1: begin
                    n_wait  = 8'd0;
                    n_phase = rmis_pkg::PH_GUARD2;
                end
                rmis_pkg::PH_ESC2: begin
                    n_wait  = 8'd0;
                    n_phase = rmis_pkg::PH_GUARD4;
                end
                rmis_pkg::PH_BAUD: begin
                    n_wait  = 8'd0;
                    n_phase = rmis_pkg::PH_BAUD_WT;
                end
                rmis_pkg::PH_BAUD_WT: begin
                    if (r_wait < r_guard) begin
                        n_wait = wait_inc;
                    end else begin
                        n_wait  = 8'd0;
                        n_phase = rmis_pkg::PH_GUARD3;
                    end
                end
                rmis_pkg::PH_SETUP: begin
                    n_wait  = 8'd0;
                    n_ok    = rmis_pkg::OKM_IDLE;
                    n_phase = rmis_pkg::PH_OK_WAIT;
                end
                rmis_pkg::PH_OK_WAIT: begin
                    n_wait = wait_inc;
                    if (wait_inc == r_timeout) n_phase = rmis_pkg::PH_HALT;
                end
                rmis_pkg::PH_EXIT: begin
                    n_wait  = 8'd0;
                    n_phase = rmis_pkg::PH_SETTLE;
                end
                rmis_pkg::PH_SETTLE: begin
                    if (r_wait < r_settle) n_wait = wait_inc;
                    else n_phase = rmis_pkg::PH_REPORT;
                end
                rmis_pkg::PH_REPORT: n_phase = rmis_pkg::PH_DONE;
                default: ;
            endcase
        end
    end

    // job issue
    always_comb begin
        o_job_req.valid = 1'b0;
        o_job_req.job   = rmis_pkg::JOB_ESCAPE;
        if (tick) begin
            unique case (r_phase)
                rmis_pkg::PH_ESC1, rmis_pkg::PH_ESC2: begin
                    o_job_req.valid = 1'b1;
                    o_job_req.job   = rmis_pkg::JOB_ESCAPE;
                end
                rmis_pkg::PH_BAUD: begin
                    o_job_req.valid = 1'b1;
                    o_job_req.job   = rmis_pkg::JOB_BAUD;
                end
                rmis_pkg::PH_BAUD_WT: begin
                    o_job_req.valid = !(r_wait < r_guard);
                    o_job_req.job   = rmis_pkg::JOB_FAST;
                end
                rmis_pkg::PH_SETUP: begin
                    o_job_req.valid = 1'b1;
                    o_job_req.job   = rmis_pkg::JOB_SETUP;
                end
                rmis_pkg::PH_OK_WAIT: begin
                    o_job_req.valid = (wait_inc == r_timeout);
                    o_job_req.job   = rmis_pkg::JOB_FAIL;
                end
                rmis_pkg::PH_EXIT: begin
                    o_job_req.valid = 1'b1;
                    o_job_req.job   = rmis_pkg::JOB_EXIT;
                end
                rmis_pkg::PH_REPORT: begin
                    o_job_req.valid = 1'b1;
                    o_job_req.job   = rmis_pkg::JOB_REPORT;
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rmis_jobq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmis_jobq
// Small job queue between the phase tracker and the message generator.
// ----------------------------------------------------------------------------
module rmis_jobq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rmis_pkg::t_job_req i_job_req,
    input  wire logic               i_rd,
    output logic                    o_full,
    output logic                    o_empty,
    output rmis_pkg::t_job          o_job
);

    rmis_pkg::t_job                 r_mem [rmis_pkg::JOBQ_DEPTH];
    logic [rmis_pkg::JOBQ_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [rmis_pkg::JOBQ_CW-1:0]   r_count;
    logic                           wr, rd;

    assign o_full  = (r_count == rmis_pkg::JOBQ_CW'(rmis_pkg::JOBQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr      = i_job_req.valid && !o_full;
    assign rd      = i_rd && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wr_ptr] <= i_job_req.job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            if (wr && !rd) r_count <= r_count + 1'b1;
            else if (rd && !wr) r_count <= r_count - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rmis_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmis_back
// Expands each job into its result items, one per cycle while the registered
// output stage is empty or being popped.
// ----------------------------------------------------------------------------
module rmis_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_jobq_empty,
    input  wire rmis_pkg::t_job     i_job,
    output logic                    o_jobq_rd,
    input  wire logic               pop,
    output logic                    empty,
    output rmis_pkg::t_result       o_result
);

    logic                           r_busy;
    rmis_pkg::t_job                 r_job;
    logic [rmis_pkg::MSG_IW-1:0]    r_idx;
    logic                           r_out_valid;
    rmis_pkg::t_result              r_out;
    logic                           load;
    logic                           is_last;

    assign o_jobq_rd = !r_busy && !i_jobq_empty;
    assign load      = r_busy && (!r_out_valid || pop);
    assign is_last   = (r_idx == rmis_pkg::job_len(r_job) - 1'b1);
    assign empty     = !r_out_valid;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_jobq_rd) begin
                r_busy <= 1'b1;
            end else if (load && is_last) begin
                r_busy <= 1'b0;
            end
            if (load) r_out_valid <= 1'b1;
            else if (pop) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_jobq_rd) begin
            r_job <= i_job;
            r_idx <= '0;
        end else if (load) begin
            r_idx <= r_idx + 1'b1;
        end
        if (load) begin
            r_out.kind    <= rmis_pkg::job_kind(r_job);
            r_out.tx_byte <= rmis_pkg::job_char(r_job, r_idx);
            r_out.last    <= is_last;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rmis_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmis_checker
// Port-level checks of the setup sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module rmis_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              full,
    input wire logic              pop,
    input wire logic              empty,
    input wire rmis_pkg::t_result o_result
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting item changed");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind != rmis_pkg::KIND_TX) |-> o_result.last)
        else $error("status item not last");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind != rmis_pkg::KIND_TX) |-> (o_result.tx_byte == 8'd0))
        else $error("status item carries data");

endmodule

bind radio_modem_init_sequencer rmis_checker u_rmis_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .o_result (o_result)
);
`default_nettype wire

// ===== verif/radio_modem_init_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// radio_modem_init_sequencer_tb
// Walks the modem setup sequencer once from reset to its end state. A short
// table covers discarded bytes, register defaults, the unused register index
// and the first sends. Random ticks and bytes then carry it through the reply
// wait to success or timeout, with registers changed between stages. Each item
// is predicted in the bench and results are compared in order under random
// gaps on both handshakes.
// ----------------------------------------------------------------------------
module radio_modem_init_sequencer_tb;

    localparam logic       CMD_TICK   = 1'b0;
    localparam logic       CMD_BYTE   = 1'b1;
    localparam logic [1:0] CFG_SPARE  = 2'd3;
    localparam logic [1:0] NO_REG     = 2'd0;
    localparam int         PAD_CYCLES = 8;
    localparam int         DIR_ROWS   = 17;

    localparam logic [8*3-1:0]  ESC_TXT   = "+++";
    localparam logic [8*6-1:0]  BAUD_TXT  = {"ATBD7", rmis_pkg::CHAR_CR};
    localparam logic [8*19-1:0] SETUP_TXT = {"ATMY20 DL18 ID6219", rmis_pkg::CHAR_CR};
    localparam logic [8*5-1:0]  EXIT_TXT  = {"ATCN", rmis_pkg::CHAR_CR};

    localparam rmis_pkg::t_result NO_RES   = '{rmis_pkg::KIND_TX, 8'h00, 1'b0};
    localparam rmis_pkg::t_result FAST_RES = '{rmis_pkg::KIND_FAST, 8'h00, 1'b1};

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_op;

    typedef struct packed {
        t_row_op            op;
        logic               cmd;
        logic [1:0]         idx;
        logic [7:0]         data;
        logic               typed;
        logic               n_exp;
        rmis_pkg::t_result  exp;
    } t_plan_row;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              push       = 1'b0;
    rmis_pkg::t_item   i_item     = '0;
    logic              pop        = 1'b0;
    logic              i_cfg_we   = 1'b0;
    logic [1:0]        i_cfg_idx  = '0;
    logic [7:0]        i_cfg_data = '0;
    logic              full;
    logic              empty;
    rmis_pkg::t_result o_result;

    // bench copy of the sequencer
    rmis_pkg::t_phase  m_phase;
    logic [7:0]        m_wait;
    rmis_pkg::t_okm    m_okm;
    logic [7:0]        m_guard;
    logic [7:0]        m_settle;
    logic [7:0]        m_timeout;

    rmis_pkg::t_result step_results [$];
    rmis_pkg::t_result exp_results [$];
    rmis_pkg::t_result head_exp;
    int                errors         = 0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    t_plan_row         plan [DIR_ROWS];

    radio_modem_init_sequencer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .pop        (pop),
        .empty      (empty),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic emit(input rmis_pkg::t_kind k, input logic [7:0] b);
        rmis_pkg::t_result r;
        r.kind    = k;
        r.tx_byte = b;
        r.last    = 1'b0;
        step_results.push_back(r);
    endtask

    task automatic emit_text(input logic [8*19-1:0] s, input int len);
        for (int i = 0; i < len; i++) begin
            emit(rmis_pkg::KIND_TX, s[8*(len-1-i) +: 8]);
        end
    endtask

    task automatic seq_predict(input rmis_pkg::t_item it);
        logic [7:0]        lim;
        rmis_pkg::t_result tail;
        step_results.delete();
        if (it.cmd == CMD_BYTE) begin
            if (m_phase == rmis_pkg::PH_OK_WAIT) begin
                m_wait = 8'd0;
                case (m_okm)
                    rmis_pkg::OKM_IDLE: begin
                        if (it.rx_byte == rmis_pkg::CHAR_O) m_okm = rmis_pkg::OKM_O;
                    end
                    rmis_pkg::OKM_O: m_okm = (it.rx_byte == rmis_pkg::CHAR_K) ?
                                             rmis_pkg::OKM_OK : rmis_pkg::OKM_IDLE;
                    default: begin
                        if (it.rx_byte == rmis_pkg::CHAR_CR) m_phase = rmis_pkg::PH_EXIT;
                    end
                endcase
            end
        end else begin
            lim = (m_phase == rmis_pkg::PH_SETTLE) ? m_settle : m_guard;
            case (m_phase)
                rmis_pkg::PH_GUARD1, rmis_pkg::PH_GUARD2, rmis_pkg::PH_GUARD3,
                rmis_pkg::PH_GUARD4, rmis_pkg::PH_SETTLE: begin
                    if (m_wait < lim) m_wait = m_wait + 8'd1;
                    else m_phase = rmis_pkg::t_phase'(m_phase + 4'd1);
                end
                rmis_pkg::PH_ESC1, rmis_pkg::PH_ESC2: begin
                    emit_text(ESC_TXT, 3);
                    m_wait  = 8'd0;
                    m_phase = rmis_pkg::t_phase'(m_phase + 4'd1);
                end
                rmis_pkg::PH_BAUD: begin
                    emit_text(BAUD_TXT, 6);
                    m_wait  = 8'd0;
                    m_phase = rmis_pkg::PH_BAUD_WT;
                end
                rmis_pkg::PH_BAUD_WT: begin
                    if (m_wait < m_guard) begin
                        m_wait = m_wait + 8'd1;
                    end else begin
                        emit(rmis_pkg::KIND_FAST, 8'h00);
                        m_wait  = 8'd0;
                        m_phase = rmis_pkg::PH_GUARD3;
                    end
                end
                rmis_pkg::PH_SETUP: begin
                    emit_text(SETUP_TXT, 19);
                    m_wait  = 8'd0;
                    m_okm   = rmis_pkg::OKM_IDLE;
                    m_phase = rmis_pkg::PH_OK_WAIT;
                end
                rmis_pkg::PH_OK_WAIT: begin
                    m_wait = m_wait + 8'd1;
                    if (m_wait == m_timeout) begin
                        emit(rmis_pkg::KIND_FAIL, 8'h00);
                        m_phase = rmis_pkg::PH_HALT;
                    end
                end
                rmis_pkg::PH_EXIT: begin
                    emit_text(EXIT_TXT, 5);
                    m_wait  = 8'd0;
                    m_phase = rmis_pkg::PH_SETTLE;
                end
                rmis_pkg::PH_REPORT: begin
                    emit(rmis_pkg::KIND_REPORT, 8'h00);
                    m_phase = rmis_pkg::PH_DONE;
                end
                default: ;
            endcase
        end
        if (step_results.size() > 0) begin
            tail = step_results.pop_back();
            tail.last = 1'b1;
            step_results.push_back(tail);
        end
    endtask

    // hand one item over, then queue what it should produce
    task automatic drive_item(input rmis_pkg::t_item it, input logic typed,
                              input logic n_exp, input rmis_pkg::t_result exp);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        seq_predict(it);
        if (typed) begin
            if (n_exp) exp_results.push_back(exp);
        end else begin
            foreach (step_results[k]) exp_results.push_back(step_results[k]);
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (exp_results.size() != 0) @(posedge i_clk);
        repeat (PAD_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            rmis_pkg::CFG_GUARD:   m_guard   = data;
            rmis_pkg::CFG_SETTLE:  m_settle  = data;
            rmis_pkg::CFG_TIMEOUT: m_timeout = data;
            default: ;
        endcase
    endtask

    function automatic logic [7:0] pick_count(input bit for_timeout);
        int r;
        r = $urandom_range(9);
        if (r == 0) return for_timeout ? 8'd1 : 8'd0;
        if (r == 1) return 8'd255;
        if (for_timeout && r == 2) return 8'd0;
        return for_timeout ? 8'($urandom_range(6, 2)) : 8'($urandom_range(4, 1));
    endfunction

    // result side: check what leaves, then decide whether to take the next one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (exp_results.size() == 0) begin
                    $error("unexpected result: kind %0d tx_byte %h last %0d",
                           o_result.kind, o_result.tx_byte, o_result.last);
                    errors++;
                end else begin
                    head_exp = exp_results.pop_front();
                    if (o_result.kind !== head_exp.kind) begin
                        $error("kind: expected %0d, got %0d", head_exp.kind, o_result.kind);
                        errors++;
                    end
                    if (o_result.tx_byte !== head_exp.tx_byte) begin
                        $error("tx_byte: expected %h, got %h",
                               head_exp.tx_byte, o_result.tx_byte);
                        errors++;
                    end
                    if (o_result.last !== head_exp.last) begin
                        $error("last: expected %0d, got %0d", head_exp.last, o_result.last);
                        errors++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        rmis_pkg::t_item it;
        int              counted;
        int              tries;
        int              next_cfg;
        int              stage;
        bit              restrained;
        logic [7:0]      nxt;

        plan = '{
            '{ROW_ITEM, CMD_BYTE, NO_REG,                8'hFF, 1'b1, 1'b0, NO_RES},
            '{ROW_ITEM, CMD_BYTE, NO_REG,                8'h00, 1'b1, 1'b0, NO_RES},
            '{ROW_ITEM, CMD_BYTE, NO_REG,    rmis_pkg::CHAR_O,  1'b1, 1'b0, NO_RES},
            '{ROW_ITEM, CMD_BYTE, NO_REG,    rmis_pkg::CHAR_CR, 1'b1, 1'b0, NO_RES},
            '{ROW_ITEM, CMD_TICK, NO_REG,                8'h00, 1'b1, 1'b0, NO_RES},
            '{ROW_ITEM, CMD_TICK, NO_REG,                8'hFF, 1'b1, 1'b0, NO_RES},
            '{ROW_CFG,  CMD_TICK, CFG_SPARE,             8'h00, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM, CMD_TICK, NO_REG,                8'h00, 1'b1, 1'b0, NO_RES},
            '{ROW_CFG,  CMD_TICK, rmis_pkg::CFG_GUARD,   8'h00, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM, CMD_TICK, NO_REG,                8'h00, 1'b1, 1'b0, NO_RES},
            '{ROW_ITEM, CMD_TICK, NO_REG,                8'h00, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM, CMD_BYTE, NO_REG,    rmis_pkg::CHAR_K,  1'b1, 1'b0, NO_RES},
            '{ROW_ITEM, CMD_TICK, NO_REG,                8'h00, 1'b1, 1'b0, NO_RES},
            '{ROW_ITEM, CMD_TICK, NO_REG,                8'h00, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM, CMD_TICK, NO_REG,                8'h00, 1'b1, 1'b1, FAST_RES},
            '{ROW_CFG,  CMD_TICK, rmis_pkg::CFG_SETTLE,  8'hFF, 1'b0, 1'b0, NO_RES},
            '{ROW_CFG,  CMD_TICK, rmis_pkg::CFG_TIMEOUT, 8'hFF, 1'b0, 1'b0, NO_RES}
        };

        m_phase   = rmis_pkg::PH_GUARD1;
        m_wait    = 8'd0;
        m_okm     = rmis_pkg::OKM_IDLE;
        m_guard   = rmis_pkg::GUARD_RST;
        m_settle  = rmis_pkg::SETTLE_RST;
        m_timeout = rmis_pkg::TIMEOUT_RST;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].op == ROW_CFG) begin
                wait_idle();
                write_reg(plan[i].idx, plan[i].data);
                i_cfg_we <= 1'b0;
            end else begin
                it.cmd     = plan[i].cmd;
                it.rx_byte = plan[i].data;
                drive_item(it, plan[i].typed, plan[i].n_exp, plan[i].exp);
            end
        end

        // random walk to the end state, reconfigured every stage
        counted  = 0;
        tries    = 0;
        next_cfg = 0;
        stage    = 0;
        while (!(m_phase inside {rmis_pkg::PH_DONE, rmis_pkg::PH_HALT}) && tries < 4000) begin
            if (counted >= next_cfg) begin
                wait_idle();
                write_reg(rmis_pkg::CFG_GUARD, pick_count(1'b0));
                write_reg(rmis_pkg::CFG_SETTLE, pick_count(1'b0));
                write_reg(rmis_pkg::CFG_TIMEOUT, pick_count(1'b1));
                if ($urandom_range(2) == 0) write_reg(CFG_SPARE, 8'($urandom_range(255)));
                i_cfg_we <= 1'b0;
                case (stage % 4)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                    default: begin send_idle_pct = 15; recv_stall_pct = 15; end
                endcase
                stage++;
                next_cfg += 30;
            end
            // hold off success and timeout until most items have gone in
            restrained = (counted < 200);
            if (m_phase == rmis_pkg::PH_OK_WAIT) begin
                nxt = m_wait + 8'd1;
                if ($urandom_range(99) < 30 && !(restrained && nxt == m_timeout)) begin
                    it.cmd     = CMD_TICK;
                    it.rx_byte = 8'($urandom_range(255));
                end else begin
                    it.cmd = CMD_BYTE;
                    case ($urandom_range(9))
                        0, 1, 2: it.rx_byte = rmis_pkg::CHAR_O;
                        3, 4:    it.rx_byte = rmis_pkg::CHAR_K;
                        5:       it.rx_byte = rmis_pkg::CHAR_CR;
                        default: it.rx_byte = 8'($urandom_range(255));
                    endcase
                    if (restrained && m_okm == rmis_pkg::OKM_OK &&
                        it.rx_byte == rmis_pkg::CHAR_CR)
                        it.rx_byte = rmis_pkg::CHAR_K;
                end
            end else begin
                it.cmd     = ($urandom_range(99) < 80) ? CMD_TICK : CMD_BYTE;
                it.rx_byte = 8'($urandom_range(255));
            end
            if (it.cmd == CMD_TICK || m_phase == rmis_pkg::PH_OK_WAIT) counted++;
            drive_item(it, 1'b0, 1'b0, NO_RES);
            tries++;
        end

        // everything after the end state is ignored
        repeat (12) begin
            it.cmd     = 1'($urandom_range(1));
            it.rx_byte = ($urandom_range(1) == 0) ? rmis_pkg::CHAR_CR : 8'($urandom_range(255));
            drive_item(it, 1'b0, 1'b0, NO_RES);
        end

        push <= 1'b0;
        recv_stall_pct = 0;
        while (exp_results.size() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
